FILE: hw/rtl/cdt_pkg.sv
// cdt_pkg: shared types, codes and helper functions for the countdown timer.
// Used by cdt_scan, cdt_count and countdown_timer_with_presets; no dependencies.
package cdt_pkg;

  // Run modes
  localparam logic [1:0] MODE_STANDBY = 2'd0;
  localparam logic [1:0] MODE_SETTING = 2'd1;
  localparam logic [1:0] MODE_RUNNING = 2'd2;
  localparam logic [1:0] MODE_PAUSE   = 2'd3;

  // Key codes
  localparam logic [2:0] KEY_NONE  = 3'd0;
  localparam logic [2:0] KEY_ONE   = 3'd1;
  localparam logic [2:0] KEY_TWO   = 3'd2;
  localparam logic [2:0] KEY_THREE = 3'd3;
  localparam logic [2:0] KEY_FOUR  = 3'd4;

  // Edited field codes
  localparam logic [1:0] FIELD_HOURS   = 2'd0;
  localparam logic [1:0] FIELD_MINUTES = 2'd1;
  localparam logic [1:0] FIELD_SECONDS = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SCAN_PERIOD  = 2'd0;
  localparam logic [1:0] CFG_LONG_PRESS   = 2'd1;
  localparam logic [1:0] CFG_REPEAT       = 2'd2;
  localparam logic [1:0] CFG_TICKS_PER_S  = 2'd3;

  // Preset store geometry (index width fixed by the preset_number port)
  localparam int PRESETS   = 5;
  localparam int PRESET_W  = 3;

  localparam logic [4:0] HOUR_MAX = 5'd23;
  localparam logic [5:0] MIN_MAX  = 6'd59;

  // Time held as separate fields; always within 00:00:00 to 23:59:59
  typedef struct packed {
    logic [4:0] h;
    logic [5:0] m;
    logic [5:0] s;
  } hms_t;

  typedef struct packed {
    logic [7:0]  scan_period;
    logic [6:0]  long_press_scans;
    logic [4:0]  repeat_scans;
    logic [15:0] ticks_per_second;
  } cfg_t;

  // State touched by a key scan
  typedef struct packed {
    logic [1:0]          mode;
    logic [PRESET_W-1:0] preset_index;
    logic [1:0]          edit_field;
    hms_t                count_time;
    hms_t                edit_time;
    logic [6:0]          hold_count_two;
    logic [6:0]          hold_count_three;
    logic [6:0]          hold_count_four;
    logic                long_done_two;
    logic                long_done_four;
    logic [2:0]          last_key;
  } scan_state_t;

  // State touched by the per-tick countdown
  typedef struct packed {
    logic [1:0]  mode;
    hms_t        count_time;
    logic [15:0] tick_counter;
    logic        led_level;
  } run_state_t;

  // Preset store write request
  typedef struct packed {
    logic                we;
    logic [PRESET_W-1:0] idx;
    hms_t                data;
  } store_wr_t;

  function automatic logic hms_valid(hms_t t);
    return (t.h <= HOUR_MAX) && (t.m <= MIN_MAX) && (t.s <= MIN_MAX);
  endfunction

  function automatic logic hms_nonzero(hms_t t);
    return (t.h != '0) || (t.m != '0) || (t.s != '0);
  endfunction

  // Raise one field, wrapping at its top value
  function automatic hms_t hms_raise(hms_t t, logic [1:0] field);
    hms_t r;
    r = t;
    case (field)
      FIELD_HOURS:   r.h = (t.h >= HOUR_MAX) ? 5'd0 : t.h + 5'd1;
      FIELD_MINUTES: r.m = (t.m >= MIN_MAX) ? 6'd0 : t.m + 6'd1;
      FIELD_SECONDS: r.s = (t.s >= MIN_MAX) ? 6'd0 : t.s + 6'd1;
      default: r = t;
    endcase
    return r;
  endfunction

  // One second down with borrow; zero stays zero
  function automatic hms_t hms_dec(hms_t t);
    hms_t r;
    r = t;
    if (t.s != '0) begin
      r.s = t.s - 6'd1;
    end else if (t.m != '0) begin
      r.s = MIN_MAX;
      r.m = t.m - 6'd1;
    end else if (t.h != '0) begin
      r.s = MIN_MAX;
      r.m = MIN_MAX;
      r.h = t.h - 5'd1;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/cdt_scan.sv
// cdt_scan: key scan step - preset selection, setting, long presses, start/pause.
// Depends on cdt_pkg.
module cdt_scan (
  input  logic [2:0]          key,
  input  cdt_pkg::cfg_t       cfg,
  input  cdt_pkg::scan_state_t cur,
  input  cdt_pkg::hms_t       store [cdt_pkg::PRESETS],
  output cdt_pkg::scan_state_t nxt,
  output cdt_pkg::store_wr_t  wr
);

  logic [2:0]    key_v;
  logic [2:0]    edge_key;
  logic [6:0]    repeat_top;
  cdt_pkg::hms_t rd_entry;
  cdt_pkg::hms_t load_val;
  cdt_pkg::scan_state_t st;
  cdt_pkg::store_wr_t   w;

  assign repeat_top = cfg.long_press_scans + {2'b00, cfg.repeat_scans};

  always_comb begin
    st = cur;
    w  = '0;

    // Codes above key four count as no key
    key_v    = (key > cdt_pkg::KEY_FOUR) ? cdt_pkg::KEY_NONE : key;
    edge_key = (key_v != cdt_pkg::KEY_NONE && key_v != cur.last_key) ? key_v
                                                                     : cdt_pkg::KEY_NONE;
    st.last_key = key_v;

    // Key one: next preset
    if ((st.mode == cdt_pkg::MODE_STANDBY || st.mode == cdt_pkg::MODE_SETTING) &&
        edge_key == cdt_pkg::KEY_ONE) begin
      st.preset_index = (st.preset_index == cdt_pkg::PRESET_W'(cdt_pkg::PRESETS - 1)) ?
                        '0 : st.preset_index + 1'b1;
    end

    // Entry read at the (possibly new) index; out-of-range entries load as zero
    rd_entry = store[st.preset_index];
    load_val = cdt_pkg::hms_valid(rd_entry) ? rd_entry : '0;

    if ((cur.mode == cdt_pkg::MODE_STANDBY || cur.mode == cdt_pkg::MODE_SETTING) &&
        edge_key == cdt_pkg::KEY_ONE) begin
      st.count_time = load_val;
    end

    // Key three: raise field, auto-repeat after a long hold
    if (key_v != cdt_pkg::KEY_THREE) begin
      st.hold_count_three = '0;
    end
    if (edge_key == cdt_pkg::KEY_THREE) begin
      if (st.mode == cdt_pkg::MODE_SETTING) begin
        st.edit_time = cdt_pkg::hms_raise(st.edit_time, st.edit_field);
      end
    end else if (st.mode == cdt_pkg::MODE_SETTING && key_v == cdt_pkg::KEY_THREE) begin
      if (st.hold_count_three < cfg.long_press_scans) begin
        st.hold_count_three = st.hold_count_three + 7'd1;
      end
    end
    if (st.mode == cdt_pkg::MODE_SETTING && key_v == cdt_pkg::KEY_THREE &&
        st.hold_count_three >= cfg.long_press_scans) begin
      st.hold_count_three = st.hold_count_three + 7'd1;
      if (st.hold_count_three == repeat_top) begin
        st.hold_count_three = cfg.long_press_scans;
        st.edit_time = cdt_pkg::hms_raise(st.edit_time, st.edit_field);
      end
    end

    // Key two: short press enters setting or moves field, long press saves
    if (key_v == cdt_pkg::KEY_TWO) begin
      if (!st.long_done_two) begin
        if (st.hold_count_two < cfg.long_press_scans) begin
          st.hold_count_two = st.hold_count_two + 7'd1;
        end else if (st.hold_count_two == cfg.long_press_scans) begin
          st.long_done_two = 1'b1;
          st.mode          = cdt_pkg::MODE_STANDBY;
          w.we             = 1'b1;
          w.idx            = st.preset_index;
          w.data           = st.edit_time;
          // Saved value is always in range, so it loads as is
          load_val         = st.edit_time;
          st.count_time    = load_val;
        end
      end
    end else if (st.hold_count_two != '0 || st.long_done_two) begin
      if (!st.long_done_two) begin
        if (st.mode != cdt_pkg::MODE_SETTING) begin
          st.mode       = cdt_pkg::MODE_SETTING;
          st.edit_field = cdt_pkg::FIELD_HOURS;
          st.edit_time  = '0;
        end else begin
          st.edit_field = (st.edit_field == cdt_pkg::FIELD_SECONDS) ?
                          cdt_pkg::FIELD_HOURS : st.edit_field + 2'd1;
        end
      end
      st.hold_count_two = '0;
      st.long_done_two  = 1'b0;
    end

    // Key four: short press starts or pauses, long press resets to the preset
    if (key_v == cdt_pkg::KEY_FOUR) begin
      if (!st.long_done_four) begin
        if (st.hold_count_four < cfg.long_press_scans) begin
          st.hold_count_four = st.hold_count_four + 7'd1;
        end else if (st.hold_count_four == cfg.long_press_scans) begin
          st.long_done_four = 1'b1;
          st.mode           = cdt_pkg::MODE_STANDBY;
          st.count_time     = load_val;
        end
      end
    end else if (st.hold_count_four != '0 || st.long_done_four) begin
      if (!st.long_done_four) begin
        if (st.mode == cdt_pkg::MODE_RUNNING) begin
          st.mode = cdt_pkg::MODE_PAUSE;
        end else begin
          if (st.mode == cdt_pkg::MODE_STANDBY) begin
            st.count_time = load_val;
          end else if (st.mode == cdt_pkg::MODE_SETTING) begin
            st.count_time = st.edit_time;
          end
          if (cdt_pkg::hms_nonzero(st.count_time)) begin
            st.mode = cdt_pkg::MODE_RUNNING;
          end
        end
      end
      st.hold_count_four = '0;
      st.long_done_four  = 1'b0;
    end
  end

  assign nxt = st;
  assign wr  = w;

endmodule

FILE: hw/rtl/cdt_count.sv
// cdt_count: per-tick countdown - tick counter, led toggle, one-second step.
// Depends on cdt_pkg.
module cdt_count (
  input  logic [15:0]        ticks_per_second,
  input  cdt_pkg::run_state_t cur,
  output cdt_pkg::run_state_t nxt
);

  logic [15:0] half_period;
  cdt_pkg::run_state_t st;

  assign half_period = ticks_per_second >> 1;

  always_comb begin
    st = cur;
    if (st.mode == cdt_pkg::MODE_RUNNING) begin
      st.tick_counter = st.tick_counter + 16'd1;
      // Led toggles on each half second
      if (st.tick_counter == half_period || st.tick_counter == ticks_per_second) begin
        st.led_level = ~st.led_level;
      end
      // Whole second taken
      if (st.tick_counter == ticks_per_second) begin
        st.tick_counter = '0;
        st.count_time   = cdt_pkg::hms_dec(st.count_time);
        if (!cdt_pkg::hms_nonzero(st.count_time)) begin
          st.mode = cdt_pkg::MODE_STANDBY;
        end
      end
    end
    if (st.mode != cdt_pkg::MODE_RUNNING) begin
      st.led_level = 1'b0;
    end
  end

  assign nxt = st;

endmodule

FILE: hw/rtl/countdown_timer_with_presets.sv
// Countdown timer, HH:MM:SS, with five stored presets; one input item per tick.
// The block takes one tick in every clock cycle while the result side accepts results, and returns
// one result per tick. Each tick is held in the input register until a single pass of scan
// and countdown logic fills the result register. The input register can take a new tick
// while a finished result waits, but holds it until that result is taken. The five-entry preset
// store sits in flip-flops that reset clears at once, so the block is ready in the
// first cycle after reset. Configuration writes are taken in any cycle.
// Depends on cdt_pkg, cdt_scan and cdt_count.
module countdown_timer_with_presets (
  input  logic        clk,
  input  logic        rst,
  // Tick channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  key_held,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  run_state,
  output logic [4:0]  shown_hours,
  output logic [5:0]  shown_minutes,
  output logic [5:0]  shown_seconds,
  output logic [1:0]  field_selected,
  output logic [2:0]  preset_number,
  output logic        led_on,
  output logic        drive_enable,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cdt_pkg::cfg_t        cfg;
  cdt_pkg::scan_state_t scan_st;
  cdt_pkg::scan_state_t scan_next;
  cdt_pkg::scan_state_t scan_post;
  cdt_pkg::scan_state_t scan_keep;
  cdt_pkg::run_state_t  run_in;
  cdt_pkg::run_state_t  run_next;
  cdt_pkg::store_wr_t   scan_wr;
  cdt_pkg::hms_t        store [cdt_pkg::PRESETS];
  cdt_pkg::hms_t        shown_next;

  logic [15:0] tick_counter;
  logic        led_level;
  logic [7:0]  scan_prescaler;
  logic [7:0]  prescaler_inc;
  logic        scan_hit;

  logic        s1_valid;
  logic [2:0]  s1_key;
  logic        advance;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_period      <= 8'd10;
      cfg.long_press_scans <= 7'd80;
      cfg.repeat_scans     <= 5'd10;
      cfg.ticks_per_second <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cdt_pkg::CFG_SCAN_PERIOD: cfg.scan_period      <= cfg_data[7:0];
        cdt_pkg::CFG_LONG_PRESS:  cfg.long_press_scans <= cfg_data[6:0];
        cdt_pkg::CFG_REPEAT:      cfg.repeat_scans     <= cfg_data[4:0];
        cdt_pkg::CFG_TICKS_PER_S: cfg.ticks_per_second <= cfg_data;
        default: cfg <= cfg;
      endcase
    end
  end

  // Input register; moves on when the result register is free or being emptied
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_key <= key_held;
    end
  end

  // Scan prescaler
  assign prescaler_inc = scan_prescaler + 8'd1;
  assign scan_hit      = (prescaler_inc == cfg.scan_period);

  cdt_scan u_scan (
    .key  (s1_key),
    .cfg  (cfg),
    .cur  (scan_st),
    .store(store),
    .nxt  (scan_next),
    .wr   (scan_wr)
  );

  assign scan_post = scan_hit ? scan_next : scan_st;

  assign run_in.mode         = scan_post.mode;
  assign run_in.count_time   = scan_post.count_time;
  assign run_in.tick_counter = tick_counter;
  assign run_in.led_level    = led_level;

  cdt_count u_count (
    .ticks_per_second(cfg.ticks_per_second),
    .cur             (run_in),
    .nxt             (run_next)
  );

  // Scan state with mode and time taken from the countdown
  always_comb begin
    scan_keep            = scan_post;
    scan_keep.mode       = run_next.mode;
    scan_keep.count_time = run_next.count_time;
  end

  // Timer state update, one tick per transfer out of the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_st        <= '0;
      tick_counter   <= '0;
      led_level      <= 1'b0;
      scan_prescaler <= '0;
    end else if (advance) begin
      scan_st        <= scan_keep;
      tick_counter   <= run_next.tick_counter;
      led_level      <= run_next.led_level;
      scan_prescaler <= scan_hit ? 8'd0 : prescaler_inc;
    end
  end

  // Preset store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cdt_pkg::PRESETS; i++) begin
        store[i] <= '0;
      end
    end else if (advance && scan_hit && scan_wr.we) begin
      store[scan_wr.idx] <= scan_wr.data;
    end
  end

  // Result register
  assign shown_next = (run_next.mode == cdt_pkg::MODE_SETTING) ? scan_post.edit_time
                                                               : run_next.count_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      run_state      <= run_next.mode;
      shown_hours    <= shown_next.h;
      shown_minutes  <= shown_next.m;
      shown_seconds  <= shown_next.s;
      field_selected <= scan_post.edit_field;
      preset_number  <= scan_post.preset_index;
      led_on         <= run_next.led_level;
      drive_enable   <= (run_next.mode == cdt_pkg::MODE_RUNNING);
    end
  end

  // Checks
  a_drive_matches_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_enable == (run_state == cdt_pkg::MODE_RUNNING)))
    else $error("drive_enable disagrees with run_state");

  a_led_only_running: assert property (@(posedge clk) disable iff (rst)
    (out_valid && led_on) |-> drive_enable)
    else $error("led lit outside running");

  a_state_holds_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(scan_st) && $stable(tick_counter)))
    else $error("timer state moved without a tick");

  a_field_in_range: assert property (@(posedge clk) disable iff (rst)
    scan_st.edit_field != 2'd3)
    else $error("edited field out of range");

  a_result_follows_tick: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("tick left no result");

endmodule
